[sv/hwth_pkg.sv]
// Shared types, constants and helper functions of the Hamming-weight tuple histogram.
package hwth_pkg;

  localparam int WINDOW_CODES = 9;
  localparam int COUNT_BITS   = 32;
  localparam int WIN_BITS     = 2 * WINDOW_CODES;
  localparam int BINS         = 1 << WIN_BITS;
  localparam int SEEN_W       = $clog2(WINDOW_CODES + 1);
  localparam int WORD_W       = 64;
  localparam int INDEX_W      = 18;
  localparam int OUT_COUNT_W  = 32;
  localparam int LIMIT_W      = 40;
  localparam int LEFT_W       = 4;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

  localparam logic [1:0] MODE_ALL  = 2'd0;
  localparam logic [1:0] MODE_LOW8 = 2'd1;
  localparam logic [1:0] MODE_LOW1 = 2'd2;

  localparam logic [1:0] CFG_MODE       = 2'd0;
  localparam logic [1:0] CFG_WORD_BYTES = 2'd1;
  localparam logic [1:0] CFG_LIMIT      = 2'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] WEIGHT_CODE [9] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2,
                                            2'd3, 2'd3, 2'd0};

  typedef struct packed {
    logic                op;
    logic [WORD_W-1:0]   word;
    logic [INDEX_W-1:0]  bin_index;
  } in_word_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] bin_count;
    logic [LIMIT_W-1:0]     windows_counted;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         use_bits_mode;
    logic [3:0]         word_bytes;
    logic [LIMIT_W-1:0] window_limit;
  } cfg_t;

  // One job for the back end: a histogram update or a bin read.
  typedef struct packed {
    logic                is_read;
    logic                full;
    logic [WIN_BITS-1:0] bin;
  } entry_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPD,
    BK_RESP
  } bk_state_e;

  function automatic logic [1:0] weight_code(logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return WEIGHT_CODE[n];
  endfunction

  function automatic logic [WIN_BITS-1:0] to_bin(logic [INDEX_W-1:0] idx);
    logic [31:0] t;
    t = 32'(idx);
    return t[WIN_BITS-1:0];
  endfunction

  function automatic logic [OUT_COUNT_W-1:0] cap_count(logic [COUNT_BITS-1:0] c);
    logic [63:0] t;
    t = 64'(c);
    if (t[63:OUT_COUNT_W] != '0) begin
      return '1;
    end
    return t[OUT_COUNT_W-1:0];
  endfunction

endpackage

[sv/hamming_weight_tuple_histogram.sv]
// A read word passes the front-end register, the job queue, the back end's idle and response
// states and the output register before its result is offered on out_valid_o.
// A pushed word yields up to eight bytes; each counted byte costs the back end a
// read-modify-write on the histogram memory, a read in the idle state and a write in the
// update state, while an uncounted byte is only popped in the idle state.
// Reset: a clearing pass zeroes all 262144 bins, one per cycle, with in_ready_o held low;
// configuration writes are taken during the pass.
module hamming_weight_tuple_histogram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  hwth_pkg::in_word_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hwth_pkg::out_word_t       out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [hwth_pkg::LIMIT_W-1:0] cfg_data_i
);

  hwth_pkg::cfg_t   cfg_q, cfg_d;
  hwth_pkg::entry_t push_entry, head;
  logic             push, pop, full, empty, clearing;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        hwth_pkg::CFG_MODE:       cfg_d.use_bits_mode = cfg_data_i[1:0];
        hwth_pkg::CFG_WORD_BYTES: cfg_d.word_bytes    = cfg_data_i[3:0];
        hwth_pkg::CFG_LIMIT:      cfg_d.window_limit  = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_bits_mode <= hwth_pkg::MODE_ALL;
      cfg_q.word_bytes    <= 4'd8;
      cfg_q.window_limit  <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hwth_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_i  (clearing),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .entry_o     (push_entry),
    .fifo_full_i (full)
  );

  hwth_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  hwth_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_o  (clearing),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/hwth_front.sv]
// Front end: takes input words, splits them into bytes and builds the code window.
module hwth_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clearing_i,
  input  hwth_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hwth_pkg::in_word_t in_data_i,
  output logic              push_o,
  output hwth_pkg::entry_t  entry_o,
  input  logic              fifo_full_i
);

  logic [hwth_pkg::LEFT_W-1:0]   left_q, left_d;
  logic [hwth_pkg::WORD_W-1:0]   src_q, src_d;
  logic                          rd_q, rd_d;
  logic [hwth_pkg::WIN_BITS-1:0] rdbin_q, rdbin_d;
  logic [hwth_pkg::WIN_BITS-1:0] win_q, win_d, win_next;
  logic [hwth_pkg::SEEN_W-1:0]   seen_q, seen_d, seen_next;
  logic [7:0]                    asm_q, asm_d, asm_next;
  logic [2:0]                    nbits_q, nbits_d;
  logic                          accept, emit;

  assign in_ready_o = !clearing_i && (left_q == '0);
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (left_q != '0) && !fifo_full_i;

  assign win_next  = hwth_pkg::WIN_BITS'({win_q, hwth_pkg::weight_code(src_q[7:0])});
  assign seen_next = (seen_q == hwth_pkg::SEEN_W'(hwth_pkg::WINDOW_CODES)) ?
                     seen_q : seen_q + 1'b1;
  assign asm_next  = asm_q | (8'(in_data_i.word[0]) << nbits_q);

  assign push_o          = emit;
  assign entry_o.is_read = rd_q;
  assign entry_o.full    = (seen_next == hwth_pkg::SEEN_W'(hwth_pkg::WINDOW_CODES));
  assign entry_o.bin     = rd_q ? rdbin_q : win_next;

  always_comb begin
    left_d  = left_q;
    src_d   = src_q;
    rd_d    = rd_q;
    rdbin_d = rdbin_q;
    win_d   = win_q;
    seen_d  = seen_q;
    asm_d   = asm_q;
    nbits_d = nbits_q;
    if (accept) begin
      rd_d    = (in_data_i.op == hwth_pkg::OP_READ);
      rdbin_d = hwth_pkg::to_bin(in_data_i.bin_index);
      src_d   = in_data_i.word;
      if (in_data_i.op == hwth_pkg::OP_READ) begin
        left_d = hwth_pkg::LEFT_W'(1);
      end else begin
        case (cfg_i.use_bits_mode)
          hwth_pkg::MODE_LOW8: begin
            left_d = hwth_pkg::LEFT_W'(1);
          end
          hwth_pkg::MODE_LOW1: begin
            // Bits gather into a byte; the byte goes out once eight are in.
            if (nbits_q == 3'd7) begin
              src_d   = hwth_pkg::WORD_W'(asm_next);
              left_d  = hwth_pkg::LEFT_W'(1);
              asm_d   = 8'd0;
              nbits_d = 3'd0;
            end else begin
              asm_d   = asm_next;
              nbits_d = nbits_q + 3'd1;
              left_d  = '0;
            end
          end
          default: begin
            left_d = (cfg_i.word_bytes > 4'd8) ? hwth_pkg::LEFT_W'(8) :
                     hwth_pkg::LEFT_W'(cfg_i.word_bytes);
          end
        endcase
      end
    end else if (emit) begin
      left_d = left_q - 1'b1;
      src_d  = src_q >> 8;
      if (!rd_q) begin
        win_d  = win_next;
        seen_d = seen_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      rd_q    <= 1'b0;
      win_q   <= '0;
      seen_q  <= '0;
      asm_q   <= 8'd0;
      nbits_q <= 3'd0;
    end else begin
      left_q  <= left_d;
      rd_q    <= rd_d;
      win_q   <= win_d;
      seen_q  <= seen_d;
      asm_q   <= asm_d;
      nbits_q <= nbits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    rdbin_q <= rdbin_d;
  end

endmodule

[sv/hwth_fifo.sv]
// Short job queue between the front end and the back end.
module hwth_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hwth_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output hwth_pkg::entry_t head_o,
  output logic             empty_o
);

  hwth_pkg::entry_t                store_q [hwth_pkg::FIFO_DEPTH];
  logic [hwth_pkg::FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [hwth_pkg::FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [hwth_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == hwth_pkg::FIFO_CNT_W'(hwth_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = store_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= entry_i;
    end
  end

endmodule

[sv/hwth_back.sv]
// Back end: histogram memory with clearing pass, saturating updates and bin reads.
module hwth_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hwth_pkg::cfg_t     cfg_i,
  output logic               clearing_o,
  input  logic               empty_i,
  input  hwth_pkg::entry_t   head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hwth_pkg::out_word_t out_data_o
);

  hwth_pkg::bk_state_e state_q, state_d;

  logic [hwth_pkg::COUNT_BITS-1:0] mem_q [hwth_pkg::BINS];
  logic [hwth_pkg::COUNT_BITS-1:0] rdata_q;
  logic [hwth_pkg::COUNT_BITS-1:0] wdata;
  logic [hwth_pkg::WIN_BITS-1:0]   raddr, waddr;
  logic                            we;

  logic [hwth_pkg::WIN_BITS-1:0] clr_q, clr_d;
  logic [hwth_pkg::WIN_BITS-1:0] upd_q, upd_d;
  logic [hwth_pkg::LIMIT_W-1:0]  total_q, total_d;
  logic                          out_valid_q, out_valid_d;
  hwth_pkg::out_word_t           out_q, out_d;
  logic                          counted;

  assign counted     = head_i.full && (total_q < cfg_i.window_limit);
  assign clearing_o  = (state_q == hwth_pkg::BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hwth_pkg::BK_CLEAR: begin
        if (clr_q == '1) begin
          state_d = hwth_pkg::BK_IDLE;
        end
      end
      hwth_pkg::BK_IDLE: begin
        if (!empty_i) begin
          if (head_i.is_read) begin
            if (!out_valid_q) begin
              state_d = hwth_pkg::BK_RESP;
            end
          end else if (counted) begin
            state_d = hwth_pkg::BK_UPD;
          end
        end
      end
      hwth_pkg::BK_UPD:  state_d = hwth_pkg::BK_IDLE;
      hwth_pkg::BK_RESP: state_d = hwth_pkg::BK_IDLE;
      default:           state_d = hwth_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = upd_q;
    wdata       = '0;
    raddr       = head_i.bin;
    clr_d       = clr_q;
    upd_d       = upd_q;
    total_d     = total_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      hwth_pkg::BK_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
      end
      hwth_pkg::BK_IDLE: begin
        if (!empty_i) begin
          // A read waits for the output register to drain; an update never waits.
          pop_o = !head_i.is_read || !out_valid_q;
          upd_d = head_i.bin;
        end
      end
      hwth_pkg::BK_UPD: begin
        we      = 1'b1;
        wdata   = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;
        total_d = total_q + 1'b1;
      end
      hwth_pkg::BK_RESP: begin
        out_valid_d           = 1'b1;
        out_d.bin_count       = hwth_pkg::cap_count(rdata_q);
        out_d.windows_counted = total_q;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hwth_pkg::BK_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upd_q <= upd_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

endmodule
